// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every edge outside reset.
`define STT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication: when the condition holds, the consequence must hold too.
`define STT_ASSERT_IMPL(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) else $error(msg);

// A condition that, when true, forces the consequence at the next edge.
`define STT_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

// ----- rtl/stt_pkg.sv -----
`default_nettype none

package stt_pkg;

  // Token text storage.
  localparam int MAX_TEXT_CHARS = 8;
  localparam int TEXT_BYTES     = 8;
  localparam int TEXT_W         = 8 * TEXT_BYTES;
  localparam int CNT_W          = 4;
  localparam int IDX_W          = 3;

  // Queue between the classifier and the output stage.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Token kinds.
  localparam logic [4:0] KIND_DATATYPE = 5'd0;
  localparam logic [4:0] KIND_RETURN   = 5'd1;
  localparam logic [4:0] KIND_IF       = 5'd2;
  localparam logic [4:0] KIND_WHILE    = 5'd3;
  localparam logic [4:0] KIND_SEMI     = 5'd4;
  localparam logic [4:0] KIND_LPAREN   = 5'd5;
  localparam logic [4:0] KIND_RPAREN   = 5'd6;
  localparam logic [4:0] KIND_LBRACE   = 5'd7;
  localparam logic [4:0] KIND_RBRACE   = 5'd8;
  localparam logic [4:0] KIND_PLUS     = 5'd9;
  localparam logic [4:0] KIND_MINUS    = 5'd10;
  localparam logic [4:0] KIND_STAR     = 5'd11;
  localparam logic [4:0] KIND_SLASH    = 5'd12;
  localparam logic [4:0] KIND_SHR      = 5'd13;
  localparam logic [4:0] KIND_SHL      = 5'd14;
  localparam logic [4:0] KIND_ASSIGN   = 5'd15;
  localparam logic [4:0] KIND_NOT      = 5'd16;
  localparam logic [4:0] KIND_NE       = 5'd17;
  localparam logic [4:0] KIND_EQ       = 5'd18;
  localparam logic [4:0] KIND_GT       = 5'd19;
  localparam logic [4:0] KIND_GE       = 5'd20;
  localparam logic [4:0] KIND_LT       = 5'd21;
  localparam logic [4:0] KIND_LE       = 5'd22;
  localparam logic [4:0] KIND_COMMA    = 5'd23;
  localparam logic [4:0] KIND_IDENT    = 5'd24;
  localparam logic [4:0] KIND_NUMBER   = 5'd25;
  localparam logic [4:0] KIND_END      = 5'd26;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_BANG   = "!";
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_COMMA  = ",";

  // The end token carries the text EOF, first character lowest.
  localparam logic [TEXT_W-1:0] END_TEXT = 64'h0000_0000_0046_4F45;
  localparam logic [CNT_W-1:0]  END_LEN  = 4'd3;

  // Keywords, packed with the first character in the lowest byte.
  localparam int NUM_KW = 8;
  localparam logic [TEXT_W-1:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0074_6E69,   // int
    64'h0000_0074_726F_6873,   // short
    64'h0000_0000_7261_6863,   // char
    64'h0000_0000_6574_7962,   // byte
    64'h0000_0000_6472_6F77,   // word
    64'h0000_6E72_7574_6572,   // return
    64'h0000_0000_0000_6669,   // if
    64'h0000_0065_6C69_6877    // while
  };
  localparam logic [CNT_W-1:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd5, 4'd4, 4'd4, 4'd4, 4'd6, 4'd2, 4'd5
  };
  localparam logic [4:0] KW_KIND [NUM_KW] = '{
    KIND_DATATYPE, KIND_DATATYPE, KIND_DATATYPE, KIND_DATATYPE, KIND_DATATYPE,
    KIND_RETURN, KIND_IF, KIND_WHILE
  };

  // Scan mode of the classifier.
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_WORD = 3'b010,
    MODE_NUM  = 3'b100
  } mode_t;

  // Operator character held back for one beat of lookahead.
  typedef enum logic [4:0] {
    HELD_NONE = 5'b00001,
    HELD_EQ   = 5'b00010,
    HELD_BANG = 5'b00100,
    HELD_LT   = 5'b01000,
    HELD_GT   = 5'b10000
  } held_t;

  // One token as it leaves the block.
  typedef struct packed {
    logic [4:0]        kind;
    logic [TEXT_W-1:0] text;
    logic [CNT_W-1:0]  len;
    logic              trunc;
  } tok_t;

  // All tokens caused by one input beat: one or two.
  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic two;
  } rec_t;

  // Kind of a finished word: a keyword if it matches one exactly.
  function automatic logic [4:0] word_kind(input logic [TEXT_W-1:0] text,
                                           input logic [CNT_W-1:0] len,
                                           input logic ovf);
    logic [4:0] k;
    k = KIND_IDENT;
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if (!ovf && text == KW_TEXT[i] && len == KW_LEN[i]) begin
        k = KW_KIND[i];
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/stt_front.sv -----
`default_nettype none

module stt_front import stt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic [7:0] char_code,
  input  wire logic end_of_input,
  output rec_t      push_rec,
  output logic      push
);

  mode_t             mode_r, mode_nxt;
  held_t             held_r, held_nxt;
  logic [TEXT_W-1:0] word_r, word_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;

  logic is_alpha, is_digit, cont;
  logic pair_hit, punct_hit;
  logic [4:0] pair_kind, punct_kind, op_kind;
  logic [7:0] op_char;
  tok_t op_tok, open_tok, pair_tok, punct_tok, end_tok;
  tok_t first_tok, second_tok;
  logic first_v, second_v;

  // Character classes.
  assign is_alpha = char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign is_digit = char_code inside {[8'h30:8'h39]};
  assign cont = (mode_r == MODE_WORD && (is_alpha || is_digit)) ||
                (mode_r == MODE_NUM && is_digit);

  // The held operator as a single-character token.
  always_comb begin
    case (held_r)
      HELD_EQ:   begin op_kind = KIND_ASSIGN; op_char = CH_EQ;   end
      HELD_BANG: begin op_kind = KIND_NOT;    op_char = CH_BANG; end
      HELD_LT:   begin op_kind = KIND_LT;     op_char = CH_LT;   end
      HELD_GT:   begin op_kind = KIND_GT;     op_char = CH_GT;   end
      default:   begin op_kind = KIND_GT;     op_char = CH_GT;   end
    endcase
  end

  // Two-character operators formed with the held character.
  always_comb begin
    pair_hit  = 1'b1;
    pair_kind = KIND_EQ;
    if (char_code == CH_EQ) begin
      case (held_r)
        HELD_EQ:   pair_kind = KIND_EQ;
        HELD_BANG: pair_kind = KIND_NE;
        HELD_LT:   pair_kind = KIND_LE;
        HELD_GT:   pair_kind = KIND_GE;
        default:   pair_hit  = 1'b0;
      endcase
    end else if (char_code == CH_LT && held_r == HELD_LT) begin
      pair_kind = KIND_SHL;
    end else if (char_code == CH_GT && held_r == HELD_GT) begin
      pair_kind = KIND_SHR;
    end else begin
      pair_hit = 1'b0;
    end
  end

  // Single-character punctuation.
  always_comb begin
    punct_hit = 1'b1;
    case (char_code)
      CH_SEMI:   punct_kind = KIND_SEMI;
      CH_LPAREN: punct_kind = KIND_LPAREN;
      CH_RPAREN: punct_kind = KIND_RPAREN;
      CH_LBRACE: punct_kind = KIND_LBRACE;
      CH_RBRACE: punct_kind = KIND_RBRACE;
      CH_PLUS:   punct_kind = KIND_PLUS;
      CH_MINUS:  punct_kind = KIND_MINUS;
      CH_STAR:   punct_kind = KIND_STAR;
      CH_SLASH:  punct_kind = KIND_SLASH;
      CH_COMMA:  punct_kind = KIND_COMMA;
      default: begin
        punct_hit  = 1'b0;
        punct_kind = KIND_SEMI;
      end
    endcase
  end

  // Candidate tokens.
  always_comb begin
    op_tok    = '{kind: op_kind, text: TEXT_W'(op_char), len: CNT_W'(1), trunc: 1'b0};
    open_tok  = '{kind: (mode_r == MODE_WORD) ? word_kind(word_r, cnt_r, ovf_r) : KIND_NUMBER,
                  text: word_r, len: cnt_r, trunc: ovf_r};
    pair_tok  = '{kind: pair_kind, text: TEXT_W'({char_code, op_char}), len: CNT_W'(2),
                  trunc: 1'b0};
    punct_tok = '{kind: punct_kind, text: TEXT_W'(char_code), len: CNT_W'(1), trunc: 1'b0};
    end_tok   = '{kind: KIND_END, text: END_TEXT, len: END_LEN, trunc: 1'b0};
  end

  // Mode update and token selection for one beat.
  always_comb begin
    mode_nxt   = mode_r;
    held_nxt   = HELD_NONE;
    word_nxt   = word_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    first_tok  = (held_r != HELD_NONE) ? op_tok : open_tok;
    first_v    = 1'b0;
    second_tok = end_tok;
    second_v   = 1'b0;
    if (end_of_input) begin
      first_v  = (held_r != HELD_NONE) || (mode_r != MODE_IDLE);
      second_v = 1'b1;
      mode_nxt = MODE_IDLE;
      word_nxt = '0;
      cnt_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else if (held_r != HELD_NONE && pair_hit) begin
      second_tok = pair_tok;
      second_v   = 1'b1;
    end else if (cont) begin
      if (cnt_r < CNT_W'(MAX_TEXT_CHARS)) begin
        word_nxt[8*cnt_r[IDX_W-1:0] +: 8] = char_code;
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end else begin
      first_v  = (held_r != HELD_NONE) || (mode_r != MODE_IDLE);
      mode_nxt = MODE_IDLE;
      word_nxt = '0;
      cnt_nxt  = '0;
      ovf_nxt  = 1'b0;
      if (is_alpha || is_digit) begin
        mode_nxt      = is_alpha ? MODE_WORD : MODE_NUM;
        word_nxt[7:0] = char_code;
        cnt_nxt       = CNT_W'(1);
      end else if (char_code == CH_EQ) begin
        held_nxt = HELD_EQ;
      end else if (char_code == CH_BANG) begin
        held_nxt = HELD_BANG;
      end else if (char_code == CH_LT) begin
        held_nxt = HELD_LT;
      end else if (char_code == CH_GT) begin
        held_nxt = HELD_GT;
      end else begin
        second_tok = punct_tok;
        second_v   = punct_hit;
      end
    end
  end

  // Pack the tokens of this beat into one queue entry.
  always_comb begin
    push_rec.tok0 = first_v ? first_tok : second_tok;
    push_rec.tok1 = second_tok;
    push_rec.two  = first_v && second_v;
    push          = in_fire && (first_v || second_v);
  end

  // Scan state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      held_r <= HELD_NONE;
      word_r <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      word_r <= word_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stt_queue.sv -----
`default_nettype none

module stt_queue import stt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire rec_t push_rec,
  input  wire logic pop,
  output rec_t      head_rec,
  output logic      empty,
  output logic      full
);

  rec_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign head_rec = entry_r[rd_r];

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stt_back.sv -----
`default_nettype none

module stt_back import stt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire rec_t head_rec,
  input  wire logic empty,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output tok_t      out_tok,
  output logic      out_last
);

  logic valid_r, valid_nxt;
  logic sel_r, sel_nxt;
  tok_t tok_r;
  logic last_r;
  logic load, head_last;
  tok_t head_tok;

  // Next token of the head entry and whether it ends that entry.
  assign load      = !valid_r || out_ready;
  assign head_tok  = sel_r ? head_rec.tok1 : head_rec.tok0;
  assign head_last = sel_r || !head_rec.two;
  assign pop       = load && !empty && head_last;

  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    if (load) begin
      valid_nxt = !empty;
      if (!empty) begin
        sel_nxt = !head_last;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      tok_r  <= head_tok;
      last_r <= head_last;
    end
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

// ----- rtl/source_text_tokenizer_core.sv -----
// A token passes from the classifier through a queue entry and then the output register.
// Throughput: one character per cycle while the queue has room; a character that closes
// a word and is punctuation itself yields two tokens, which leave the output one by one.
// A four-entry queue between classifier and output stage absorbs such bursts.
// Reset (rst_n low, synchronous) clears the scan mode, held operator, word buffer
// and queue; no tokens are pending afterwards.
`default_nettype none

module source_text_tokenizer_core import stt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [63:0] token_text, [67:64] text_length,
                                       // [68] text_truncated, [71:69] zero
  output logic [4:0]       out_tuser,  // [4:0] token_kind
  output logic             out_tlast   // last_of_run
);

  rec_t push_rec, head_rec;
  logic push, pop, empty, full, in_fire;
  tok_t out_tok;

  // The classifier takes a beat whenever the queue has room.
  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;

  stt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .char_code    (in_tdata),
    .end_of_input (in_tlast),
    .push_rec     (push_rec),
    .push         (push)
  );

  stt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (empty),
    .full     (full)
  );

  stt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_rec  (head_rec),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (out_tok),
    .out_last  (out_tlast)
  );

  // Output beat packing.
  assign out_tdata = {3'b000, out_tok.trunc, out_tok.len, out_tok.text};
  assign out_tuser = out_tok.kind;

endmodule

`default_nettype wire

// ----- rtl/stt_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module stt_checker import stt_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata,
  input wire logic [4:0]  out_tuser,
  input wire logic        out_tlast
);

  // A stalled result beat keeps its contents.
  `STT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "output beat changed while stalled")

  // Only defined token kinds leave the block.
  `STT_ASSERT_IMPL(a_kind_range, out_tvalid, out_tuser <= KIND_END, "token kind out of range")

  // A truncated token always carries a full text buffer.
  `STT_ASSERT_IMPL(a_trunc_len, out_tvalid && out_tdata[68], out_tdata[67:64] == CNT_W'(MAX_TEXT_CHARS), "truncated token without full length")

  // The end token closes its run and carries the text EOF.
  `STT_ASSERT_IMPL(a_end_tok, out_tvalid && out_tuser == KIND_END, out_tlast && out_tdata[63:0] == END_TEXT && out_tdata[67:64] == END_LEN, "malformed end token")

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (.*);

`default_nettype wire
